>>> src/trrb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trrb_pkg
// Operation codes, register indexes and header constants of the trace ring.
// ----------------------------------------------------------------------------
package trrb_pkg;
  localparam logic [2:0] OP_BYTE  = 3'd0;
  localparam logic [2:0] OP_RUN   = 3'd1;
  localparam logic [2:0] OP_DATA  = 3'd2;
  localparam logic [2:0] OP_ERASE = 3'd3;
  localparam logic [2:0] OP_DRAIN = 3'd4;
  localparam logic [2:0] OP_CLEAR = 3'd5;

  localparam logic [1:0] REG_ENABLE = 2'd0;
  localparam logic [1:0] REG_BYTE   = 2'd1;
  localparam logic [1:0] REG_RUN    = 2'd2;
  localparam logic [1:0] REG_ERASE  = 2'd3;

  localparam int HDR_BYTES = 12;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] target_address;
    logic [31:0] event_length;
    logic [31:0] cycle_stamp;
    logic [7:0]  payload_byte;
  } in_word_t;

  typedef struct packed {
    logic        accepted;
    logic [7:0]  read_byte;
    logic        read_valid;
    logic [63:0] drop_count;
    logic [12:0] bytes_used;
  } out_word_t;
endpackage
`default_nettype wire

>>> src/trrb_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trrb_if
// Valid/ready channel carrying one word.
// ----------------------------------------------------------------------------
interface trrb_if #(parameter type word_t = logic) ();
  logic  valid;
  logic  ready;
  word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> src/trace_record_ring_buffer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trace_record_ring_buffer
// Byte ring of trace records in one synchronous memory.
// ----------------------------------------------------------------------------
// One word is taken at a time, and the result sits in an output register
// until taken. A stored byte event writes 13 bytes to the ring memory, one
// per cycle, before the result shows; a stored erase writes 12; a run
// payload byte writes 1, or 13 where a chunk header goes first; a drain that
// finds a byte reads it through the registered memory output (S_RD, then
// S_RDW); every other word, dropped records included, writes nothing. The
// single memory write port sets this pace. A new word is taken only after
// the result has been taken.
module trace_record_ring_buffer
  import trrb_pkg::*;
#(
  parameter int BUFFER_BYTES = 4096,
  parameter int CHUNK_BYTES  = 1024
) (
  input  wire         clk,
  input  wire         rst,
  trrb_if.sink        in_ch,
  trrb_if.source      out_ch,
  input  wire         cfg_we,
  input  wire  [1:0]  cfg_index,
  input  wire  [7:0]  cfg_data
);
  localparam int AW = $clog2(BUFFER_BYTES);
  localparam int CW = AW + 1;
  localparam logic [CW:0] DEPTH = (CW+1)'(BUFFER_BYTES);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_HDR  = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_RDW  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  localparam logic [1:0] KIND_EVENT = 2'd0;
  localparam logic [1:0] KIND_ERASE = 2'd1;
  localparam logic [1:0] KIND_CHUNK = 2'd2;

  logic [7:0] ring [BUFFER_BYTES];
  logic [7:0] rd_q;

  logic [2:0]  state;
  logic        trace_enabled;
  logic [7:0]  byte_code, run_code, erase_code;
  logic [CW-1:0] write_cursor, read_cursor, pending_cursor, cur;
  logic [63:0] dropped;
  logic        run_open;
  logic [31:0] run_left, run_offset, run_base, run_stamp;
  logic [15:0] chunk_pos;
  logic [3:0]  hidx;
  logic [3:0]  hlast;
  logic [7:0]  h_type;
  logic [15:0] h_len;
  logic [31:0] h_addr, h_stamp;
  logic [7:0]  h_data;
  logic [1:0]  h_kind;
  logic        out_valid;
  out_word_t   res;

  function automatic logic [CW-1:0] used(input logic [CW-1:0] f,
                                         input logic [CW-1:0] r);
    return f - r;
  endfunction

  in_word_t w;
  assign w = in_ch.data;
  assign in_ch.ready = (state == S_IDLE) && !out_valid;
  assign out_ch.valid = out_valid;
  assign out_ch.data = res;

  logic [CW:0] fr_w, fr_p;
  assign fr_w = DEPTH - {1'b0, used(write_cursor, read_cursor)};
  assign fr_p = DEPTH - {1'b0, used(pending_cursor, read_cursor)};

  logic [31:0] chunk_n;
  assign chunk_n = (run_left < 32'(CHUNK_BYTES)) ? run_left : 32'(CHUNK_BYTES);
  logic chunk_fit;
  assign chunk_fit = {{(31-CW){1'b0}}, fr_p} > (32'(HDR_BYTES) + chunk_n);
  // payload offset within the current chunk, tracked instead of a modulo
  logic at_chunk;
  assign at_chunk = (chunk_pos == 16'd0);

  logic [7:0] hbyte;
  always_comb begin
    case (hidx)
      4'd0: hbyte = h_type;
      4'd1: hbyte = 8'd0;
      4'd2: hbyte = h_len[7:0];
      4'd3: hbyte = h_len[15:8];
      4'd4: hbyte = h_addr[7:0];
      4'd5: hbyte = h_addr[15:8];
      4'd6: hbyte = h_addr[23:16];
      4'd7: hbyte = h_addr[31:24];
      4'd8: hbyte = h_stamp[7:0];
      4'd9: hbyte = h_stamp[15:8];
      4'd10: hbyte = h_stamp[23:16];
      4'd11: hbyte = h_stamp[31:24];
      default: hbyte = h_data;
    endcase
  end

  // memory port
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [7:0]    mem_wd;
  assign mem_we = (state == S_HDR);
  assign mem_wa = cur[AW-1:0];
  assign mem_wd = hbyte;
  always_ff @(posedge clk) begin
    if (mem_we) ring[mem_wa] <= mem_wd;
    rd_q <= ring[read_cursor[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      trace_enabled <= 1'b0;
      byte_code <= 8'd0;
      run_code <= 8'd1;
      erase_code <= 8'd2;
      write_cursor <= '0;
      read_cursor <= '0;
      pending_cursor <= '0;
      dropped <= '0;
      run_open <= 1'b0;
      run_left <= '0;
      run_offset <= '0;
      run_base <= '0;
      run_stamp <= '0;
      chunk_pos <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ENABLE: trace_enabled <= cfg_data[0];
          REG_BYTE:   byte_code <= cfg_data;
          REG_RUN:    run_code <= cfg_data;
          REG_ERASE:  erase_code <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ch.ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            res.accepted <= 1'b0;
            res.read_byte <= 8'd0;
            res.read_valid <= 1'b0;
            h_addr <= w.target_address;
            h_stamp <= w.cycle_stamp;
            h_data <= w.payload_byte;
            hidx <= 4'd0;
            state <= S_OUT;
            case (w.operation)
              OP_BYTE: if (trace_enabled) begin
                run_open <= 1'b0;
                pending_cursor <= write_cursor;
                if (fr_w > (CW+1)'(HDR_BYTES + 1)) begin
                  h_type <= byte_code; h_len <= 16'd1; hlast <= 4'd12;
                  h_kind <= KIND_EVENT; cur <= write_cursor; res.accepted <= 1'b1;
                  state <= S_HDR;
                end else dropped <= dropped + 64'd1;
              end
              OP_RUN: if (trace_enabled) begin
                run_open <= 1'b0;
                pending_cursor <= write_cursor;
                if (w.event_length != 32'd0) begin
                  run_open <= 1'b1; run_left <= w.event_length;
                  run_offset <= '0; run_base <= w.target_address;
                  run_stamp <= w.cycle_stamp; res.accepted <= 1'b1;
                  chunk_pos <= '0;
                end
              end
              OP_DATA: if (trace_enabled && run_open) begin
                h_type <= run_code; h_len <= chunk_n[15:0];
                h_addr <= run_base + run_offset; h_stamp <= run_stamp;
                h_kind <= KIND_CHUNK; cur <= pending_cursor;
                if (at_chunk && !chunk_fit) begin
                  dropped <= dropped + 64'd1;
                  run_open <= 1'b0;
                  pending_cursor <= write_cursor;
                end else begin
                  hidx <= at_chunk ? 4'd0 : 4'd12;
                  hlast <= 4'd12; res.accepted <= 1'b1; state <= S_HDR;
                end
              end
              OP_ERASE: if (trace_enabled) begin
                run_open <= 1'b0;
                pending_cursor <= write_cursor;
                if (fr_w > (CW+1)'(HDR_BYTES)) begin
                  h_type <= erase_code; h_len <= w.event_length[15:0];
                  hlast <= 4'd11; h_kind <= KIND_ERASE; cur <= write_cursor;
                  res.accepted <= 1'b1; state <= S_HDR;
                end else dropped <= dropped + 64'd1;
              end
              OP_DRAIN: if (read_cursor != write_cursor) state <= S_RD;
              OP_CLEAR: begin
                run_open <= 1'b0;
                pending_cursor <= write_cursor;
                read_cursor <= write_cursor;
                dropped <= '0;
              end
              default: ;
            endcase
          end
        end
        S_HDR: begin
          cur <= cur + 1'b1;
          hidx <= hidx + 4'd1;
          if (hidx == hlast) begin
            state <= S_OUT;
            if (h_kind == KIND_CHUNK) begin
              pending_cursor <= cur + 1'b1;
              run_offset <= run_offset + 32'd1;
              run_left <= run_left - 32'd1;
              chunk_pos <= (chunk_pos == 16'(CHUNK_BYTES - 1)) ? 16'd0
                                                               : chunk_pos + 16'd1;
              if (run_left == 32'd1) begin
                write_cursor <= cur + 1'b1;
                run_open <= 1'b0;
              end
            end else begin
              write_cursor <= cur + 1'b1;
              pending_cursor <= cur + 1'b1;
            end
          end
        end
        S_RD: state <= S_RDW;
        S_RDW: begin
          res.read_byte <= rd_q;
          res.read_valid <= 1'b1;
          read_cursor <= read_cursor + 1'b1;
          state <= S_OUT;
        end
        S_OUT: begin
          res.drop_count <= dropped;
          res.bytes_used <= 13'(used(write_cursor, read_cursor));
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> dv/trrb_ring_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trrb_ring_checker
// Watches the input, output and register ports of the trace ring, keeps its
// own copy of the ring and run state, and compares every output word with
// the oldest predicted one.
// ----------------------------------------------------------------------------
module trrb_ring_checker
  import trrb_pkg::*;
#(
  parameter int BUFFER_BYTES = 4096,
  parameter int CHUNK_BYTES  = 1024
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        in_valid,
  input  wire        in_ready,
  input  in_word_t   in_data,
  input  wire        out_valid,
  input  wire        out_ready,
  input  out_word_t  out_data,
  input  wire        cfg_we,
  input  wire [1:0]  cfg_index,
  input  wire [7:0]  cfg_data,
  output int         fail_count,
  output int         waiting
);
  logic [7:0]  ring_mem [BUFFER_BYTES];
  logic [12:0] wr_ptr, rd_ptr, pend_ptr;
  logic [63:0] drops;
  logic        run_active;
  logic [31:0] run_left, run_pos, run_addr, run_time;
  logic        trace_on;
  logic [7:0]  byte_code, run_code, erase_code;
  out_word_t   expected_results [$];

  // cursors run modulo 2*BUFFER_BYTES; 13 bits wrap there naturally
  function automatic logic room_for(logic [12:0] from, int need);
    logic [12:0] used;
    used = from - rd_ptr;
    return (BUFFER_BYTES - int'(used)) > need;
  endfunction

  task automatic push_byte(inout logic [12:0] p, input logic [7:0] v);
    ring_mem[p % BUFFER_BYTES] = v;
    p = p + 13'd1;
  endtask

  task automatic push_header(inout logic [12:0] p, input logic [7:0] code,
                             input logic [15:0] len, input logic [31:0] addr,
                             input logic [31:0] stamp);
    push_byte(p, code);
    push_byte(p, 8'h00);
    push_byte(p, len[7:0]);
    push_byte(p, len[15:8]);
    for (int k = 0; k < 32; k += 8) push_byte(p, addr[k +: 8]);
    for (int k = 0; k < 32; k += 8) push_byte(p, stamp[k +: 8]);
  endtask

  task automatic drop_run();
    run_active = 1'b0;
    pend_ptr   = wr_ptr;
  endtask

  task automatic predict_word(input in_word_t w);
    out_word_t r;
    int        n;
    r = '0;
    case (w.operation)
      OP_BYTE: if (trace_on) begin
        drop_run();
        if (room_for(wr_ptr, HDR_BYTES + 1)) begin
          push_header(wr_ptr, byte_code, 16'd1, w.target_address, w.cycle_stamp);
          push_byte(wr_ptr, w.payload_byte);
          pend_ptr   = wr_ptr;
          r.accepted = 1'b1;
        end else drops++;
      end
      OP_RUN: if (trace_on) begin
        drop_run();
        if (w.event_length != 0) begin
          run_active = 1'b1;
          run_left   = w.event_length;
          run_pos    = 0;
          run_addr   = w.target_address;
          run_time   = w.cycle_stamp;
          r.accepted = 1'b1;
        end
      end
      OP_DATA: if (trace_on && run_active) begin
        r.accepted = 1'b1;
        if (run_pos % CHUNK_BYTES == 0) begin
          n = (run_left < CHUNK_BYTES) ? int'(run_left) : CHUNK_BYTES;
          if (room_for(pend_ptr, HDR_BYTES + n))
            push_header(pend_ptr, run_code, 16'(n), run_addr + run_pos, run_time);
          else begin
            drops++;
            drop_run();
            r.accepted = 1'b0;
          end
        end
        if (r.accepted) begin
          push_byte(pend_ptr, w.payload_byte);
          run_pos++;
          run_left--;
          if (run_left == 0) begin
            wr_ptr     = pend_ptr;
            run_active = 1'b0;
          end
        end
      end
      OP_ERASE: if (trace_on) begin
        drop_run();
        if (room_for(wr_ptr, HDR_BYTES)) begin
          push_header(wr_ptr, erase_code, w.event_length[15:0], w.target_address,
                      w.cycle_stamp);
          pend_ptr   = wr_ptr;
          r.accepted = 1'b1;
        end else drops++;
      end
      OP_DRAIN: if (rd_ptr != wr_ptr) begin
        r.read_byte  = ring_mem[rd_ptr % BUFFER_BYTES];
        r.read_valid = 1'b1;
        rd_ptr       = rd_ptr + 13'd1;
      end
      OP_CLEAR: begin
        drop_run();
        rd_ptr = wr_ptr;
        drops  = 0;
      end
      default: ;
    endcase
    r.drop_count = drops;
    r.bytes_used = wr_ptr - rd_ptr;
    expected_results.push_back(r);
  endtask

  task automatic report(input string field, input logic [63:0] got,
                        input logic [63:0] want);
    $display("%0t mismatch on %s: got %0h, want %0h", $realtime, field, got, want);
    fail_count++;
  endtask

  task automatic check_word(input out_word_t got);
    out_word_t want;
    if (expected_results.size() == 0) begin
      report("unexpected word", 64'(got), 64'd0);
      return;
    end
    want = expected_results.pop_front();
    if (got.accepted !== want.accepted)
      report("accepted", 64'(got.accepted), 64'(want.accepted));
    if (got.read_byte !== want.read_byte)
      report("read_byte", 64'(got.read_byte), 64'(want.read_byte));
    if (got.read_valid !== want.read_valid)
      report("read_valid", 64'(got.read_valid), 64'(want.read_valid));
    if (got.drop_count !== want.drop_count)
      report("drop_count", got.drop_count, want.drop_count);
    if (got.bytes_used !== want.bytes_used)
      report("bytes_used", 64'(got.bytes_used), 64'(want.bytes_used));
  endtask

  initial begin
    fail_count = 0;
    waiting    = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      wr_ptr     = '0;
      rd_ptr     = '0;
      pend_ptr   = '0;
      drops      = '0;
      run_active = 1'b0;
      run_left   = '0;
      run_pos    = '0;
      run_addr   = '0;
      run_time   = '0;
      trace_on   = 1'b0;
      byte_code  = 8'd0;
      run_code   = 8'd1;
      erase_code = 8'd2;
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ENABLE: trace_on   = cfg_data[0];
          REG_BYTE:   byte_code  = cfg_data;
          REG_RUN:    run_code   = cfg_data;
          REG_ERASE:  erase_code = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) check_word(out_data);
      if (in_valid && in_ready) predict_word(in_data);
    end
    waiting <= expected_results.size();
  end
endmodule

>>> dv/trace_record_ring_buffer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trace_record_ring_buffer_test
// Drives directed and random trace words with random idling on both sides,
// moves the registers between phases and gives the verdict from the checker.
// ----------------------------------------------------------------------------
module trace_record_ring_buffer_test;
  import trrb_pkg::*;

  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;
  int         fail_count;
  int         waiting;
  int         words_sent;
  bit         quiet;
  bit         hold_req;

  trrb_if #(.word_t(in_word_t))  in_ch ();
  trrb_if #(.word_t(out_word_t)) out_ch ();

  trace_record_ring_buffer uut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  trrb_ring_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .waiting(waiting)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #8000000;
    $display("trace_record_ring_buffer_test NOT OK");
    $finish;
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else out_ch.ready <= 1'b1;
    end
  end

  function automatic in_word_t make_word(logic [2:0] op, logic [31:0] addr,
                                         logic [31:0] len, logic [31:0] stamp,
                                         logic [7:0] data);
    in_word_t w;
    w.operation      = op;
    w.target_address = addr;
    w.event_length   = len;
    w.cycle_stamp    = stamp;
    w.payload_byte   = data;
    return w;
  endfunction

  function automatic in_word_t rand_word(logic [2:0] op, logic [31:0] len);
    return make_word(op, $urandom, len, $urandom, 8'($urandom));
  endfunction

  task automatic send_word(input in_word_t w);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    words_sent++;
  endtask

  // only with nothing in flight
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic send_run(input int len, input bit may_break);
    send_word(rand_word(OP_RUN, 32'(len)));
    for (int i = 0; i < len; i++) begin
      if (may_break && $urandom_range(0, 40) == 0) return;
      send_word(rand_word(OP_DATA, 32'd0));
    end
  endtask

  task automatic random_phase(input int count, input int drain_weight);
    int pick;
    int target;
    target = words_sent + count;
    while (words_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < drain_weight)
        repeat ($urandom_range(1, 12)) send_word(rand_word(OP_DRAIN, $urandom));
      else if (pick < drain_weight + 25) send_run($urandom_range(1, 24), 1'b1);
      else if (pick < drain_weight + 45) send_word(rand_word(OP_BYTE, $urandom));
      else if (pick < drain_weight + 55) send_word(rand_word(OP_ERASE, $urandom));
      else if (pick < drain_weight + 57) send_word(rand_word(OP_CLEAR, $urandom));
      else if (pick < drain_weight + 59) send_word(rand_word(OP_RUN, 32'd0));
      else if (pick < drain_weight + 61) send_word(rand_word(OP_RUN, $urandom));
      else if (pick < drain_weight + 64) send_word(rand_word(OP_DATA, $urandom));
      else if (pick < drain_weight + 66)
        send_word(rand_word($urandom_range(0, 1) ? OP_SPARE_LO : OP_SPARE_HI, $urandom));
      else send_word(rand_word(OP_DRAIN, $urandom));
    end
  endtask

  initial begin
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = REG_ENABLE;
    cfg_data     = 8'd0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    words_sent   = 0;
    quiet        = 1'b0;
    hold_req     = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // tracing off: emits ignored, drain of empty ring
    send_word(make_word(OP_BYTE, '1, '1, '1, 8'hFF));
    send_word(make_word(OP_DRAIN, '0, '0, '0, 8'h00));
    write_reg(REG_ENABLE, 8'd1);
    send_word(make_word(OP_BYTE, '0, '0, '0, 8'h00));
    send_word(make_word(OP_BYTE, '1, '1, '1, 8'hFF));
    send_word(make_word(OP_ERASE, 32'hFFFF_FFFF, 32'h0001_FFFF, '1, 8'hFF));
    send_word(make_word(OP_RUN, 32'h1234_5678, 32'd0, '0, 8'h00));
    send_word(make_word(OP_DATA, '0, '0, '0, 8'hA5));
    send_run(3, 1'b0);
    send_word(make_word(OP_RUN, 32'hFFFF_FFFE, 32'd5, '1, 8'h00));
    send_word(make_word(OP_DATA, '0, '0, '0, 8'h5A));
    send_word(make_word(OP_BYTE, '0, '0, '0, 8'h3C));
    send_word(make_word(OP_DATA, '0, '0, '0, 8'hC3));
    send_word(make_word(OP_SPARE_LO, '1, '1, '1, 8'hFF));
    send_word(make_word(OP_SPARE_HI, '1, '1, '1, 8'hFF));
    repeat (4) send_word(make_word(OP_DRAIN, '0, '0, '0, 8'h00));
    send_word(make_word(OP_CLEAR, '0, '0, '0, 8'h00));
    send_word(make_word(OP_DRAIN, '0, '0, '0, 8'h00));
    // run left open across a disabled stretch
    send_word(make_word(OP_RUN, 32'h10, 32'd2, 32'h20, 8'h00));
    write_reg(REG_ENABLE, 8'd0);
    send_word(make_word(OP_DATA, '0, '0, '0, 8'h11));
    write_reg(REG_ENABLE, 8'd1);
    repeat (2) send_word(make_word(OP_DATA, '0, '0, '0, 8'h22));

    // extreme codes; run across a chunk boundary from an empty ring, then
    // byte events until the ring is full and records drop; long hold-off
    write_reg(REG_BYTE, 8'd255);
    write_reg(REG_RUN, 8'd0);
    write_reg(REG_ERASE, 8'd255);
    send_word(rand_word(OP_CLEAR, 32'd0));
    hold_req = 1'b1;
    send_run(1025, 1'b0);
    repeat (240) send_word(rand_word(OP_BYTE, $urandom));
    repeat (2) send_word(rand_word(OP_ERASE, $urandom));
    // first chunk header no longer fits
    send_run(4, 1'b0);

    for (int ph = 0; ph < 3; ph++) begin
      write_reg(REG_ENABLE, (ph == 1) ? 8'($urandom_range(0, 1)) : 8'd1);
      write_reg(REG_BYTE, 8'($urandom));
      write_reg(REG_RUN, 8'($urandom));
      write_reg(REG_ERASE, 8'($urandom));
      if (ph == 2) quiet = 1'b1;
      random_phase(20, 35);
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (fail_count == 0 && waiting == 0)
      $display("trace_record_ring_buffer_test OK");
    else
      $display("trace_record_ring_buffer_test NOT OK");
    $finish;
  end
endmodule

>>> sim.f
src/trrb_pkg.sv
src/trrb_if.sv
src/trace_record_ring_buffer.sv
dv/trrb_ring_checker.sv
dv/trace_record_ring_buffer_test.sv
